// File: sv/tbrb_pkg.sv
package tbrb_pkg;

   localparam logic [1:0] KIND_ELEMENT  = 2'd0;
   localparam logic [1:0] KIND_RUN      = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic take_item;    // register the accepted item
      logic div_start;    // start the divider
      logic div_step;     // one quotient bit
      logic mul_start;    // start quotient * size
      logic mul_step;     // one multiplier bit
      logic elem_done;    // latch bucket value, update range
      logic scan_step;    // compare entry at scan pointer
      logic apply;        // write increment, decide insert
      logic shift_rd;     // issue read of the entry below the shift pointer
      logic shift_step;   // move one entry up, or drop in the new key
      logic emit_elem;    // load element result
      logic emit_run;     // load run result from read data
      logic emit_ovf;     // load overflow result
      logic end_set;      // close the set
   } tbrb_cmd_type;

   typedef struct packed {
      logic div_done;
      logic mul_done;
      logic scan_done;
      logic shift_done;
      logic run_done;
      logic last_item;
      logic out_busy;
      logic ovf;
   } tbrb_sts_type;

endpackage

// File: sv/tbrb_if.sv
interface tbrb_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] timestamp;
   logic [30:0] base_index;
   logic        last;
   modport source (output valid, timestamp, base_index, last, input ready);
   modport sink (input valid, timestamp, base_index, last, output ready);
endinterface

interface tbrb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] bucket_value;
   logic [30:0] run_start;
   logic [30:0] run_end;
   logic [31:0] range_low;
   logic [31:0] range_high;
   logic        last_result;
   modport source (output valid, kind, bucket_value, run_start, run_end, range_low,
      range_high, last_result, input ready);
   modport sink (input valid, kind, bucket_value, run_start, run_end, range_low,
      range_high, last_result, output ready);
endinterface

interface tbrb_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: sv/tbrb_ram.sv
module tbrb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/tbrb_datapath.sv
module tbrb_datapath #(
   parameter int MAX_BUCKETS = 16,
   parameter int COUNT_WIDTH = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  tbrb_pkg::tbrb_cmd_type cmd,
   output tbrb_pkg::tbrb_sts_type sts,
   input  logic [31:0]        req_timestamp,
   input  logic [30:0]        req_base_index,
   input  logic               req_last,
   input  logic               csr_valid,
   input  logic [31:0]        csr_data,
   tbrb_rsp_if.source         rsp
);
   import tbrb_pkg::*;

   localparam int AW = $clog2(MAX_BUCKETS);
   localparam int UW = AW + 1;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam int ENTRY_W = 32 + COUNT_WIDTH;

   logic [31:0] size_ff;
   logic [31:0] ts_ff;
   logic        last_ff;
   logic [31:0] bs;
   // divider
   logic [31:0] quo_ff;
   logic [32:0] rem_ff;
   logic [5:0]  bit_ff;
   // multiplier
   logic [31:0] prod_ff;
   logic [31:0] mcand_ff;
   logic [31:0] mplier_ff;
   logic [31:0] value_ff;
   // set state
   logic [UW-1:0] used_ff;
   logic [30:0]   base_ff;
   logic          in_set_ff;
   logic          ovf_ff;
   logic [31:0]   low_ff;
   logic [31:0]   high_ff;
   // scan and shift
   logic [UW-1:0] ptr_ff;
   logic          hit_ff;
   logic          found_ff;
   logic [COUNT_WIDTH-1:0] hit_cnt_ff;
   logic [UW-1:0] sh_ff;
   logic          ins_ff;
   logic [30:0]   accum_ff;
   // output register
   logic          ov_ff;
   logic [1:0]    okind_ff;
   logic [31:0]   oval_ff;
   logic [30:0]   ostart_ff;
   logic [30:0]   oend_ff;
   logic [31:0]   olow_ff;
   logic [31:0]   ohigh_ff;
   logic          olast_ff;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [31:0]       rd_key;
   logic [COUNT_WIDTH-1:0] rd_cnt;
   logic [32:0]       rem_sh;
   logic [30:0]       run_end;
   logic              insert_now;

   assign bs     = (size_ff == 32'd0) ? 32'd1 : size_ff;
   assign rd_key = rd_data[ENTRY_W-1:COUNT_WIDTH];
   assign rd_cnt = rd_data[COUNT_WIDTH-1:0];
   assign rem_sh = {rem_ff[31:0], ts_ff[5'd31 - bit_ff[4:0]]};
   assign run_end = accum_ff + 31'(rd_cnt);
   assign insert_now = !ovf_ff && !found_ff && used_ff != UW'(MAX_BUCKETS);

   tbrb_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BUCKETS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read address: scan or run pointer, shift preload, or shift source.
   always_comb begin
      rd_addr = ptr_ff[AW-1:0];
      if (cmd.shift_step) begin
         rd_addr = AW'(sh_ff - UW'(2));
      end else if (cmd.shift_rd) begin
         rd_addr = AW'(sh_ff - UW'(1));
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff[AW-1:0];
      wr_data = {value_ff, COUNT_WIDTH'(1)};
      if (cmd.shift_step) begin
         if (sh_ff != ptr_ff) begin
            // rd_data holds entry sh-1; move it up to sh
            wr_en   = 1'b1;
            wr_addr = AW'(sh_ff);
            wr_data = rd_data;
         end else begin
            // slot at the scan pointer is free now
            wr_en = ins_ff;
         end
      end else if (cmd.apply && !ovf_ff && found_ff) begin
         wr_en   = hit_cnt_ff != CNT_MAX;
         wr_data = {value_ff, hit_cnt_ff + COUNT_WIDTH'(1)};
      end
   end

   assign sts.div_done   = bit_ff == 6'd32;
   assign sts.mul_done   = mplier_ff == 32'd0;
   assign sts.scan_done  = hit_ff || ptr_ff == used_ff;
   assign sts.shift_done = sh_ff == ptr_ff;
   assign sts.run_done   = ptr_ff == used_ff;
   assign sts.last_item  = last_ff;
   assign sts.out_busy   = ov_ff && !rsp.ready;
   assign sts.ovf        = ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= 32'd1;
         used_ff   <= '0;
         base_ff   <= '0;
         in_set_ff <= 1'b0;
         ovf_ff    <= 1'b0;
         low_ff    <= '1;
         high_ff   <= '0;
         ov_ff     <= 1'b0;
         bit_ff    <= 6'd32;
      end else begin
         if (csr_valid) begin
            size_ff <= csr_data;
         end
         if (cmd.emit_elem || cmd.emit_ovf || cmd.emit_run) begin
            ov_ff <= 1'b1;
         end else if (ov_ff && rsp.ready) begin
            ov_ff <= 1'b0;
         end
         if (cmd.take_item) begin
            ts_ff   <= req_timestamp;
            last_ff <= req_last;
            if (!in_set_ff) begin
               in_set_ff <= 1'b1;
               base_ff   <= req_base_index;
               used_ff   <= '0;
               ovf_ff    <= 1'b0;
            end
         end
         if (cmd.div_start) begin
            rem_ff <= '0;
            quo_ff <= '0;
            bit_ff <= 6'd0;
         end else if (cmd.div_step) begin
            // restoring division, MSB first
            if (rem_sh >= {1'b0, bs}) begin
               rem_ff <= rem_sh - {1'b0, bs};
               quo_ff <= {quo_ff[30:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[30:0], 1'b0};
            end
            bit_ff <= bit_ff + 6'd1;
         end
         if (cmd.mul_start) begin
            prod_ff   <= '0;
            mcand_ff  <= bs;
            mplier_ff <= quo_ff;
         end else if (cmd.mul_step) begin
            if (mplier_ff[0]) begin
               prod_ff <= prod_ff + mcand_ff;
            end
            mcand_ff  <= {mcand_ff[30:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[31:1]};
         end
         if (cmd.elem_done) begin
            value_ff <= prod_ff;
            if (prod_ff > high_ff) high_ff <= prod_ff;
            if (prod_ff < low_ff) low_ff <= prod_ff;
            ptr_ff   <= '0;
            hit_ff   <= 1'b0;
            found_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            // rd_data holds entry ptr
            if (rd_key >= value_ff) begin
               hit_ff     <= 1'b1;
               found_ff   <= rd_key == value_ff;
               hit_cnt_ff <= rd_cnt;
            end else begin
               ptr_ff <= ptr_ff + UW'(1);
            end
         end
         if (cmd.apply) begin
            // shift only when a new key goes in
            sh_ff  <= insert_now ? used_ff : ptr_ff;
            ins_ff <= insert_now;
            if (!ovf_ff) begin
               if (found_ff) begin
                  if (hit_cnt_ff == CNT_MAX) ovf_ff <= 1'b1;
               end else if (used_ff == UW'(MAX_BUCKETS)) begin
                  ovf_ff <= 1'b1;
               end else begin
                  used_ff <= used_ff + UW'(1);
               end
            end
         end
         if (cmd.shift_step && sh_ff != ptr_ff) begin
            sh_ff <= sh_ff - UW'(1);
         end
         if (cmd.emit_elem) begin
            okind_ff  <= KIND_ELEMENT;
            oval_ff   <= value_ff;
            ostart_ff <= '0;
            oend_ff   <= '0;
            olow_ff   <= low_ff;
            ohigh_ff  <= high_ff;
            olast_ff  <= !last_ff;
            ptr_ff    <= '0;
            accum_ff  <= base_ff;
         end
         if (cmd.emit_ovf) begin
            okind_ff  <= KIND_OVERFLOW;
            oval_ff   <= '0;
            ostart_ff <= base_ff;
            oend_ff   <= '0;
            olow_ff   <= low_ff;
            ohigh_ff  <= high_ff;
            olast_ff  <= 1'b1;
         end
         if (cmd.emit_run) begin
            okind_ff  <= KIND_RUN;
            oval_ff   <= rd_key;
            ostart_ff <= accum_ff;
            oend_ff   <= run_end;
            olow_ff   <= low_ff;
            ohigh_ff  <= high_ff;
            olast_ff  <= ptr_ff + UW'(1) == used_ff;
            accum_ff  <= run_end;
            ptr_ff    <= ptr_ff + UW'(1);
         end
         if (cmd.end_set) begin
            in_set_ff <= 1'b0;
            used_ff   <= '0;
            ovf_ff    <= 1'b0;
         end
      end
   end

   assign rsp.valid        = ov_ff;
   assign rsp.kind         = okind_ff;
   assign rsp.bucket_value = oval_ff;
   assign rsp.run_start    = ostart_ff;
   assign rsp.run_end      = oend_ff;
   assign rsp.range_low    = olow_ff;
   assign rsp.range_high   = ohigh_ff;
   assign rsp.last_result  = olast_ff;
endmodule

// File: sv/tbrb_ctrl.sv
module tbrb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output tbrb_pkg::tbrb_cmd_type cmd,
   input  tbrb_pkg::tbrb_sts_type sts
);
   import tbrb_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DIV     = 4'd1;
   localparam logic [3:0] S_MUL     = 4'd2;
   localparam logic [3:0] S_ELEM    = 4'd3;
   localparam logic [3:0] S_SREAD   = 4'd4;
   localparam logic [3:0] S_SCMP    = 4'd5;
   localparam logic [3:0] S_APPLY   = 4'd6;
   localparam logic [3:0] S_SHRD    = 4'd7;
   localparam logic [3:0] S_SHIFT   = 4'd8;
   localparam logic [3:0] S_EMIT    = 4'd9;
   localparam logic [3:0] S_RREAD   = 4'd10;
   localparam logic [3:0] S_RWAIT   = 4'd11;
   localparam logic [3:0] S_RUN     = 4'd12;
   localparam logic [3:0] S_END     = 4'd13;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_item = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.mul_start = 1'b1;
               state_in      = S_MUL;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_MUL: begin
            if (sts.mul_done) begin
               state_in = S_ELEM;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         S_ELEM: begin
            cmd.elem_done = 1'b1;
            state_in      = S_SREAD;
         end
         S_SREAD: begin
            // wait for the registered read at the scan pointer
            if (sts.ovf) begin
               state_in = S_EMIT;
            end else if (sts.scan_done) begin
               state_in = S_APPLY;
            end else begin
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            cmd.scan_step = 1'b1;
            state_in      = S_SREAD;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_SHRD;
         end
         S_SHRD: begin
            // preload: read entry sh-1
            cmd.shift_rd = 1'b1;
            state_in     = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (sts.shift_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!sts.out_busy) begin
               cmd.emit_elem = 1'b1;
               state_in      = sts.last_item ? S_RREAD : S_IDLE;
            end
         end
         S_RREAD: begin
            if (sts.ovf) begin
               if (!sts.out_busy) begin
                  cmd.emit_ovf = 1'b1;
                  state_in     = S_END;
               end
            end else if (sts.run_done) begin
               state_in = S_END;
            end else begin
               state_in = S_RWAIT;
            end
         end
         S_RWAIT: begin
            state_in = S_RUN;
         end
         S_RUN: begin
            if (!sts.out_busy) begin
               cmd.emit_run = 1'b1;
               state_in     = S_RREAD;
            end
         end
         S_END: begin
            cmd.end_set = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: sv/temporal_bucket_run_builder_unit.sv
// Channel  Direction  Carries
// req      in         timestamp, base_index, last
// rsp      out        kind, bucket_value, run_start, run_end, range_low/high, last_result
// csr      in         bucket_size write data
//
// Each item runs a 32-step restoring divider, a shift-add multiplier of up to
// 32 steps, a table scan that reads and then compares each entry, and a
// one-entry-per-cycle shift through the table RAM. A last item then reads
// the table back and emits its runs or an overflow result. Reset is synchronous; the table
// needs no clearing. Results wait in one output register while rsp stalls.
module temporal_bucket_run_builder_unit #(
   parameter int MAX_BUCKETS = 16,
   parameter int COUNT_WIDTH = 24
) (
   input logic         clock,
   input logic         reset,
   tbrb_req_if.sink    req,
   tbrb_rsp_if.source  rsp,
   tbrb_csr_if.sink    csr
);
   import tbrb_pkg::*;

   tbrb_cmd_type cmd;
   tbrb_sts_type sts;

   assign csr.ready = 1'b1;

   tbrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   tbrb_datapath #(.MAX_BUCKETS(MAX_BUCKETS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_timestamp  (req.timestamp),
      .req_base_index (req.base_index),
      .req_last       (req.last),
      .csr_valid      (csr.valid),
      .csr_data       (csr.data),
      .rsp            (rsp)
   );
endmodule
